### rtl/core/assert_macros.svh
// Assertion macros shared by the formatter RTL.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/ifa_pkg.sv
// Shared types, constants and helpers of the integer-to-ASCII formatter.
// No dependencies; used by ifa_bcd_cell and integer_to_ascii_formatter_unit.
`default_nettype none

package ifa_pkg;

  localparam int unsigned NumDigits = 20;
  localparam int unsigned ValueW    = 64;
  localparam int unsigned CountW    = 7;
  localparam int unsigned DigitCntW = 5;

  // Format codes
  localparam logic [2:0] ActSigned      = 3'd0;
  localparam logic [2:0] ActSignedPad   = 3'd1;
  localparam logic [2:0] ActUnsigned    = 3'd2;
  localparam logic [2:0] ActUnsignedPad = 3'd3;
  localparam logic [2:0] ActHex         = 3'd4;
  localparam logic [2:0] ActBinary      = 3'd5;

  // Operand width codes
  localparam logic [1:0] Width8  = 2'd0;
  localparam logic [1:0] Width16 = 2'd1;
  localparam logic [1:0] Width32 = 2'd2;
  localparam logic [1:0] Width64 = 2'd3;

  localparam logic [7:0] CharZero   = 8'h30;
  localparam logic [7:0] CharUpperA = 8'h41;
  localparam logic [7:0] CharSpace  = 8'h20;
  localparam logic [7:0] CharMinus  = 8'h2D;
  localparam logic [7:0] CharNone   = 8'h00;

  typedef struct packed {
    logic [2:0]  action;
    logic [1:0]  width_code;
    logic [63:0] value;
  } ifa_in_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
    logic       error;
  } ifa_out_t;

  // Control broadcast to every digit cell
  typedef struct packed {
    logic clear;
    logic dabble;
    logic move;
  } cell_ctrl_t;

  // Field width of a padded decimal for an unsigned operand
  function automatic logic [DigitCntW-1:0] pad_width(input logic [1:0] wcode);
    logic [DigitCntW-1:0] w;
    case (wcode)
      Width8:  w = DigitCntW'(3);
      Width16: w = DigitCntW'(5);
      Width32: w = DigitCntW'(10);
      Width64: w = DigitCntW'(20);
      default: w = DigitCntW'(20);
    endcase
    return w;
  endfunction

  // Uppercase hex character of one nibble
  function automatic logic [7:0] nibble_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = CharZero + {4'b0, nib};
    end else begin
      c = CharUpperA + {4'b0, nib} - 8'd10;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/integer_to_ascii_formatter_unit.sv
// Top level of the integer-to-ASCII formatter: sequencer, operand shifter, output register.
// Depends on ifa_pkg, ifa_bcd_cell and assert_macros.svh.
`default_nettype none

// Takes one word (format, width code, value) at a time and sends its text as one ASCII
// character per output word, last set on the final one. Decimal formats run the magnitude
// through a row of 20 BCD cells, one bit per cycle, then drop leading zero digits and
// shift the digits out of the top cell, after any pad spaces and minus sign. Hex and
// binary words send nibbles or bits from the top of the aligned operand; an invalid
// format sends one error word. A new input word is taken once the previous word's
// last character has been loaded into the output register.
module integer_to_ascii_formatter_unit (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  ifa_pkg::ifa_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output ifa_pkg::ifa_out_t out_data_o
);
  import ifa_pkg::*;

`include "assert_macros.svh"

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_CONV  = 8'b0000_0010,
    S_NORM  = 8'b0000_0100,
    S_PAD   = 8'b0000_1000,
    S_SIGN  = 8'b0001_0000,
    S_DIGIT = 8'b0010_0000,
    S_RAW   = 8'b0100_0000,
    S_ERR   = 8'b1000_0000
  } state_e;

  state_e               state_q, state_d;
  logic                 out_valid_q, out_valid_d;
  ifa_out_t             out_q, out_d;
  logic [ValueW-1:0]    work_q, work_d;
  logic [CountW-1:0]    count_q, count_d;
  logic [DigitCntW-1:0] digits_q, digits_d;
  logic [DigitCntW-1:0] pad_q, pad_d;
  logic [1:0]           wcode_q, wcode_d;
  logic                 signed_q, signed_d;
  logic                 padded_q, padded_d;
  logic                 hex_q, hex_d;
  logic                 neg_q, neg_d;

  cell_ctrl_t           cell_ctrl;
  logic                 carry [NumDigits];
  logic [3:0]           digit [NumDigits];
  logic [3:0]           top_digit;

  logic [ValueW-1:0]    in_raw, in_ext, in_mag, in_aligned;
  logic                 in_sign, in_is_signed, in_neg;
  logic [CountW-1:0]    in_raw_len;
  logic [DigitCntW-1:0] field, text_len;
  logic                 can_emit, emit;
  ifa_out_t             emit_word;

  // Row of BCD digit cells, least significant at index 0
  for (genvar i = 0; i < NumDigits; i++) begin : g_cell
    ifa_bcd_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (cell_ctrl),
      .carry_i ((i == 0) ? work_q[ValueW-1] : carry[(i == 0) ? 0 : i - 1]),
      .digit_i ((i == 0) ? 4'd0 : digit[(i == 0) ? 0 : i - 1]),
      .carry_o (carry[i]),
      .digit_o (digit[i])
    );
  end

  assign top_digit = digit[NumDigits-1];

  // Mask, extend and align the incoming operand
  always_comb begin
    case (in_data_i.width_code)
      Width8: begin
        in_raw     = {56'b0, in_data_i.value[7:0]};
        in_sign    = in_data_i.value[7];
        in_aligned = {in_data_i.value[7:0], 56'b0};
      end
      Width16: begin
        in_raw     = {48'b0, in_data_i.value[15:0]};
        in_sign    = in_data_i.value[15];
        in_aligned = {in_data_i.value[15:0], 48'b0};
      end
      Width32: begin
        in_raw     = {32'b0, in_data_i.value[31:0]};
        in_sign    = in_data_i.value[31];
        in_aligned = {in_data_i.value[31:0], 32'b0};
      end
      default: begin
        in_raw     = in_data_i.value;
        in_sign    = in_data_i.value[63];
        in_aligned = in_data_i.value;
      end
    endcase
    in_is_signed = (in_data_i.action == ActSigned) || (in_data_i.action == ActSignedPad);
    in_neg       = in_is_signed && in_sign;
    in_ext       = in_raw;
    case (in_data_i.width_code)
      Width8:  in_ext = in_neg ? {{56{1'b1}}, in_raw[7:0]}  : in_raw;
      Width16: in_ext = in_neg ? {{48{1'b1}}, in_raw[15:0]} : in_raw;
      Width32: in_ext = in_neg ? {{32{1'b1}}, in_raw[31:0]} : in_raw;
      default: in_ext = in_raw;
    endcase
    in_mag     = in_neg ? (ValueW'(0) - in_ext) : in_ext;
    in_raw_len = (in_data_i.action == ActHex) ? (CountW'(2) << in_data_i.width_code)
                                              : (CountW'(8) << in_data_i.width_code);
  end

  // Pad length from the trimmed digit count
  always_comb begin
    field    = pad_width(wcode_q) + DigitCntW'(signed_q && (wcode_q != Width64));
    text_len = digits_q + DigitCntW'(neg_q);
  end

  assign can_emit = !out_valid_q || out_ready_i;

  // Sequencer
  always_comb begin
    state_d   = state_q;
    work_d    = work_q;
    count_d   = count_q;
    digits_d  = digits_q;
    pad_d     = pad_q;
    wcode_d   = wcode_q;
    signed_d  = signed_q;
    padded_d  = padded_q;
    hex_d     = hex_q;
    neg_d     = neg_q;
    cell_ctrl = '0;
    emit      = 1'b0;
    emit_word = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          wcode_d  = in_data_i.width_code;
          signed_d = in_is_signed;
          padded_d = (in_data_i.action == ActSignedPad) ||
                     (in_data_i.action == ActUnsignedPad);
          hex_d    = (in_data_i.action == ActHex);
          neg_d    = in_neg;
          if (in_data_i.action inside {[ActSigned:ActUnsignedPad]}) begin
            work_d          = in_mag;
            count_d         = CountW'(ValueW);
            cell_ctrl.clear = 1'b1;
            state_d         = S_CONV;
          end else if (in_data_i.action inside {ActHex, ActBinary}) begin
            work_d  = in_aligned;
            count_d = in_raw_len;
            state_d = S_RAW;
          end else begin
            state_d = S_ERR;
          end
        end
      end
      S_CONV: begin
        // Shift one magnitude bit into the cell row
        cell_ctrl.dabble = 1'b1;
        work_d           = work_q << 1;
        count_d          = count_q - CountW'(1);
        if (count_q == CountW'(1)) begin
          digits_d = DigitCntW'(NumDigits);
          state_d  = S_NORM;
        end
      end
      S_NORM: begin
        // Drop leading zero digits, keep at least one
        if (top_digit == 4'd0 && digits_q != DigitCntW'(1)) begin
          cell_ctrl.move = 1'b1;
          digits_d       = digits_q - DigitCntW'(1);
        end else begin
          pad_d   = (padded_q && field > text_len) ? field - text_len : '0;
          state_d = S_PAD;
        end
      end
      S_PAD: begin
        if (pad_q == '0) begin
          state_d = neg_q ? S_SIGN : S_DIGIT;
        end else if (can_emit) begin
          emit                = 1'b1;
          emit_word.character = CharSpace;
          pad_d               = pad_q - DigitCntW'(1);
        end
      end
      S_SIGN: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_word.character = CharMinus;
          state_d             = S_DIGIT;
        end
      end
      S_DIGIT: begin
        // Send the top digit and advance the row
        if (can_emit) begin
          emit                = 1'b1;
          emit_word.character = CharZero + {4'b0, top_digit};
          emit_word.last      = (digits_q == DigitCntW'(1));
          cell_ctrl.move      = 1'b1;
          digits_d            = digits_q - DigitCntW'(1);
          if (digits_q == DigitCntW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_RAW: begin
        // Send hex nibbles or bits from the top of the aligned operand
        if (can_emit) begin
          emit                = 1'b1;
          emit_word.character = hex_q ? nibble_char(work_q[ValueW-1 -: 4])
                                      : CharZero + {7'b0, work_q[ValueW-1]};
          emit_word.last      = (count_q == CountW'(1));
          work_d              = hex_q ? (work_q << 4) : (work_q << 1);
          count_d             = count_q - CountW'(1);
          if (count_q == CountW'(1)) begin
            state_d = S_IDLE;
          end
        end
      end
      S_ERR: begin
        if (can_emit) begin
          emit                = 1'b1;
          emit_word.character = CharNone;
          emit_word.last      = 1'b1;
          emit_word.error     = 1'b1;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: load on emit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (emit) begin
      out_valid_d = 1'b1;
      out_d       = emit_word;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      count_q     <= '0;
      digits_q    <= '0;
      pad_q       <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      count_q     <= count_d;
      digits_q    <= digits_d;
      pad_q       <= pad_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    work_q   <= work_d;
    wcode_q  <= wcode_d;
    signed_q <= signed_d;
    padded_q <= padded_d;
    hex_q    <= hex_d;
    neg_q    <= neg_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_NEXT(a_bad_action_err, in_valid_i && in_ready_o && in_data_i.action > ActBinary, state_q == S_ERR, "invalid format did not reach error state")
  `ASSERT_IMPL(a_top_cell_no_carry, state_q == S_CONV, !carry[NumDigits-1], "decimal conversion overflowed the digit row")
  `ASSERT_IMPL(a_digit_count_range, state_q == S_DIGIT, digits_q != '0 && digits_q <= DigitCntW'(NumDigits), "digit count out of range")
  `ASSERT_NEXT(a_last_to_idle, emit && emit_word.last, state_q == S_IDLE, "sequencer busy after last character")

endmodule

`default_nettype wire

### rtl/core/ifa_bcd_cell.sv
// One decimal digit cell of the double-dabble row.
// Depends on ifa_pkg for the cell control struct.
`default_nettype none

module ifa_bcd_cell (
  input  logic                clk_i,
  input  ifa_pkg::cell_ctrl_t ctrl_i,
  input  logic                carry_i,
  input  logic [3:0]          digit_i,
  output logic                carry_o,
  output logic [3:0]          digit_o
);
  import ifa_pkg::*;

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  // Add three to digits of five or more before the shift
  always_comb begin
    adj     = (digit_q >= 4'd5) ? digit_q + 4'd3 : digit_q;
    carry_o = adj[3];
    digit_o = digit_q;
  end

  // Clear, shift in the lower carry, or take the lower neighbor's digit
  always_comb begin
    digit_d = digit_q;
    if (ctrl_i.clear) begin
      digit_d = 4'd0;
    end else if (ctrl_i.dabble) begin
      digit_d = {adj[2:0], carry_i};
    end else if (ctrl_i.move) begin
      digit_d = digit_i;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

endmodule

`default_nettype wire
